@@ rtl/core/afd_pkg.sv @@
`default_nettype none

package afd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 1;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgStartDelim = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxLen     = 1'b1;

  localparam logic [ByteW-1:0] ResetDelim  = 8'h7E;
  localparam logic [LenW-1:0]  ResetMaxLen = 16'd512;
  localparam logic [ByteW-1:0] SumBase     = 8'hFF;

  typedef enum logic [1:0] {
    KindData    = 2'd0,
    KindGood    = 2'd1,
    KindCsumErr = 2'd2,
    KindLenErr  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] start_delim;
    logic [LenW-1:0]  max_len;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data_byte;
    logic             first_of_frame;
    logic [LenW-1:0]  frame_length;
  } result_t;

  // Parser to output stage: a result and whether it moves this cycle.
  typedef struct packed {
    logic    valid;
    result_t res;
  } emit_t;

endpackage

`default_nettype wire

@@ rtl/core/afd_rx_if.sv @@
`default_nettype none

interface afd_rx_if;
  logic                      valid;
  logic                      ready;
  logic [afd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/core/afd_res_if.sv @@
`default_nettype none

interface afd_res_if;
  logic                      valid;
  logic                      ready;
  afd_pkg::kind_e            result_kind;
  logic [afd_pkg::ByteW-1:0] data_byte;
  logic                      first_of_frame;
  logic [afd_pkg::LenW-1:0]  frame_length;

  modport source (output valid, output result_kind, output data_byte,
                  output first_of_frame, output frame_length, input ready);
  modport sink   (input valid, input result_kind, input data_byte,
                  input first_of_frame, input frame_length, output ready);
endinterface

`default_nettype wire

@@ rtl/core/afd_cfg_regs.sv @@
`default_nettype none

module afd_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [afd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [afd_pkg::CfgW-1:0]    cfg_wdata_i,
  output afd_pkg::cfg_t                    cfg_o
);

  afd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        afd_pkg::CfgStartDelim: cfg_d.start_delim = cfg_wdata_i[afd_pkg::ByteW-1:0];
        afd_pkg::CfgMaxLen:     cfg_d.max_len     = cfg_wdata_i[afd_pkg::LenW-1:0];
        default:                cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_delim <= afd_pkg::ResetDelim;
      cfg_q.max_len     <= afd_pkg::ResetMaxLen;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/afd_parser.sv @@
`default_nettype none

module afd_parser (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire afd_pkg::cfg_t cfg_i,
  afd_rx_if.sink      rx,
  input  wire logic   slot_free_i,
  output afd_pkg::emit_t emit_o
);

  typedef enum logic [2:0] {
    PhHunt  = 3'd0,
    PhLenHi = 3'd1,
    PhLenLo = 3'd2,
    PhData  = 3'd3,
    PhCheck = 3'd4
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [afd_pkg::LenW-1:0]  len_q, len_d;
  logic [afd_pkg::LenW-1:0]  seen_q, seen_d;
  logic [afd_pkg::ByteW-1:0] sum_q, sum_d;
  logic [afd_pkg::ByteW-1:0] byte_q;
  logic                      busy_q;

  logic                      produces;
  logic                      advance;
  logic [afd_pkg::LenW-1:0]  len_full;
  logic [afd_pkg::ByteW-1:0] expect_sum;
  afd_pkg::result_t          res;

  assign len_full   = {len_q[afd_pkg::LenW-1:afd_pkg::ByteW], byte_q};
  assign expect_sum = afd_pkg::SumBase - sum_q;

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    seen_d   = seen_q;
    sum_d    = sum_q;
    produces = 1'b0;
    res.kind           = afd_pkg::KindData;
    res.data_byte      = '0;
    res.first_of_frame = 1'b0;
    res.frame_length   = len_q;
    unique case (phase_q)
      PhHunt: begin
        if (byte_q == cfg_i.start_delim) phase_d = PhLenHi;
      end
      PhLenHi: begin
        len_d   = {byte_q, {afd_pkg::ByteW{1'b0}}};
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        len_d            = len_full;
        seen_d           = '0;
        sum_d            = '0;
        res.frame_length = len_full;
        if (len_full > cfg_i.max_len) begin
          produces = 1'b1;
          res.kind = afd_pkg::KindLenErr;
          phase_d  = PhHunt;
        end else begin
          phase_d = (len_full == '0) ? PhCheck : PhData;
        end
      end
      PhData: begin
        produces           = 1'b1;
        res.data_byte      = byte_q;
        res.first_of_frame = (seen_q == '0);
        sum_d              = sum_q + byte_q;
        seen_d             = seen_q + 1'b1;
        if (seen_d >= len_q) phase_d = PhCheck;
      end
      PhCheck: begin
        produces = 1'b1;
        res.kind = (byte_q == expect_sum) ? afd_pkg::KindGood : afd_pkg::KindCsumErr;
        phase_d  = PhHunt;
      end
      default: phase_d = PhHunt;
    endcase
  end

  // A byte that yields no result can always retire; one with a result waits
  // for room in the output stage.
  assign advance      = busy_q && (!produces || slot_free_i);
  assign rx.ready     = !busy_q || advance;
  assign emit_o.valid = busy_q && produces && slot_free_i;
  assign emit_o.res   = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      len_q   <= '0;
      seen_q  <= '0;
      sum_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      if (advance) begin
        phase_q <= phase_d;
        len_q   <= len_d;
        seen_q  <= seen_d;
        sum_q   <= sum_d;
      end
      if (rx.valid && rx.ready) begin
        busy_q <= 1'b1;
      end else if (advance) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx.valid && rx.ready) byte_q <= rx.rx_byte;
  end

  a_data_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhData |-> seen_q < len_q)
    else $error("data phase with all bytes already counted");

  a_len_err_resync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && phase_q == PhLenLo && len_full > cfg_i.max_len) |=> phase_q == PhHunt)
    else $error("oversized length did not return to hunting");

  a_data_only_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.valid && emit_o.res.kind == afd_pkg::KindData) |-> phase_q == PhData)
    else $error("data result outside the data phase");

endmodule

`default_nettype wire

@@ rtl/core/afd_out_stage.sv @@
`default_nettype none

module afd_out_stage (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire afd_pkg::emit_t emit_i,
  output logic           slot_free_o,
  afd_res_if.source      res
);

  logic             valid_q;
  afd_pkg::result_t res_q;

  assign slot_free_o = !valid_q || res.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit_i.valid) begin
      valid_q <= 1'b1;
    end else if (res.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.valid) res_q <= emit_i.res;
  end

  assign res.valid          = valid_q;
  assign res.result_kind    = res_q.kind;
  assign res.data_byte      = res_q.data_byte;
  assign res.first_of_frame = res_q.first_of_frame;
  assign res.frame_length   = res_q.frame_length;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res.ready) |-> !emit_i.valid)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

@@ rtl/core/api_frame_deframer_top.sv @@
// Channel   Dir  Payload                                            Transfer
// rx_if     in   rx_byte[7:0]                                       valid & ready
// res_if    out  result_kind, data_byte, first_of_frame,
//                frame_length[15:0]                                 valid & ready
// cfg       in   cfg_idx_i (0 delimiter, 1 max length), cfg_wdata_i cfg_we_i
//
// One byte per cycle while the result output does not stall: a byte is held
// in the input register, then updates the frame state and, if it yields a
// result, loads the result register.
// Reset clears the frame state to hunting and loads 0x7E and 512.
// A stalled result output holds back only bytes that yield a result.
`default_nettype none

module api_frame_deframer_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  afd_rx_if.sink                           rx_if,
  afd_res_if.source                        res_if,
  input  wire logic                        cfg_we_i,
  input  wire logic [afd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [afd_pkg::CfgW-1:0]    cfg_wdata_i
);

  afd_pkg::cfg_t  cfg;
  afd_pkg::emit_t emit;
  logic           slot_free;

  afd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  afd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .rx          (rx_if),
    .slot_free_i (slot_free),
    .emit_o      (emit)
  );

  afd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .slot_free_o (slot_free),
    .res         (res_if)
  );

endmodule

`default_nettype wire
